[design/crc32_rbs_pkg.sv]
// shared constants for the reflected byte-stream crc block
package crc32_rbs_pkg;

   localparam int unsigned CRC_WIDTH      = 32;
   localparam int unsigned BYTE_WIDTH     = 8;
   localparam int unsigned STEPS_PER_BYTE = 8;

   localparam logic [CRC_WIDTH-1:0] POLY_RESET = 32'h436f_7265;
   localparam logic [CRC_WIDTH-1:0] CRC_INIT   = '0;

endpackage

[design/crc32_rbs_req_if.sv]
// request channel: one message byte per transfer
interface crc32_rbs_req_if;

   logic                                   valid;
   logic                                   ready;
   logic [crc32_rbs_pkg::BYTE_WIDTH-1:0]   data_byte;
   logic                                   last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);

endinterface

[design/crc32_rbs_rsp_if.sv]
// response channel: one finished crc per transfer
interface crc32_rbs_rsp_if;

   logic                                   valid;
   logic                                   ready;
   logic [crc32_rbs_pkg::CRC_WIDTH-1:0]    crc_value;

   modport source (output valid, output crc_value, input ready);
   modport sink   (input valid, input crc_value, output ready);

endinterface

[design/crc32_rbs_fold.sv]
// folds one byte into the crc remainder with eight unrolled shift steps
module crc32_rbs_fold (
   input  logic [crc32_rbs_pkg::CRC_WIDTH-1:0]  rem_cur,
   input  logic [crc32_rbs_pkg::BYTE_WIDTH-1:0] data_byte,
   input  logic [crc32_rbs_pkg::CRC_WIDTH-1:0]  polynomial,
   output logic [crc32_rbs_pkg::CRC_WIDTH-1:0]  rem_next
);

   always_comb begin
      logic [crc32_rbs_pkg::CRC_WIDTH-1:0] rem_v;
      logic                                out_bit;
      rem_v = rem_cur ^ {{(crc32_rbs_pkg::CRC_WIDTH - crc32_rbs_pkg::BYTE_WIDTH){1'b0}},
                         data_byte};
      for (int i = 0; i < int'(crc32_rbs_pkg::STEPS_PER_BYTE); i++) begin
         out_bit = rem_v[0];
         rem_v   = rem_v >> 1;
         if (out_bit) begin
            rem_v = rem_v ^ polynomial;
         end
      end
      rem_next = rem_v;
   end

endmodule

[design/crc32_rbs_core.sv]
// input register, byte fold and result register of the reflected crc
module crc32_rbs_core (
   input  logic                                 clock,
   input  logic                                 reset,
   crc32_rbs_req_if.sink                        req,
   crc32_rbs_rsp_if.source                      rsp,
   input  logic [crc32_rbs_pkg::CRC_WIDTH-1:0]  polynomial
);

   logic                                   s1_valid_ff;
   logic                                   s1_valid_in;
   logic [crc32_rbs_pkg::BYTE_WIDTH-1:0]   s1_byte_ff;
   logic                                   s1_last_ff;
   logic [crc32_rbs_pkg::CRC_WIDTH-1:0]    remainder_ff;
   logic [crc32_rbs_pkg::CRC_WIDTH-1:0]    remainder_in;
   logic                                   out_valid_ff;
   logic                                   out_valid_in;
   logic [crc32_rbs_pkg::CRC_WIDTH-1:0]    out_crc_ff;
   logic [crc32_rbs_pkg::CRC_WIDTH-1:0]    fold_out;
   logic                                   s1_adv;
   logic                                   s1_fire;
   logic                                   in_ready;

   crc32_rbs_fold u_fold (
      .rem_cur    (remainder_ff),
      .data_byte  (s1_byte_ff),
      .polynomial (polynomial),
      .rem_next   (fold_out)
   );

   // a non-last byte never needs the result register
   assign s1_adv   = !s1_last_ff || !out_valid_ff || rsp.ready;
   assign s1_fire  = s1_valid_ff && s1_adv;
   assign in_ready = !s1_valid_ff || s1_adv;

   always_comb begin
      s1_valid_in  = in_ready ? req.valid : s1_valid_ff;
      remainder_in = remainder_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      if (s1_fire) begin
         remainder_in = s1_last_ff ? crc32_rbs_pkg::CRC_INIT : fold_out;
         if (s1_last_ff) begin
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         remainder_ff <= crc32_rbs_pkg::CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         remainder_ff <= remainder_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         s1_byte_ff <= req.data_byte;
         s1_last_ff <= req.last_byte;
      end
      if (s1_fire && s1_last_ff) begin
         out_crc_ff <= fold_out;
      end
   end

   assign req.ready     = in_ready;
   assign rsp.valid     = out_valid_ff;
   assign rsp.crc_value = out_crc_ff;

endmodule

[design/crc32_reflected_byte_stream_core.sv]
// a last byte accepted on req passes the input register, and its fold result is
// registered in the result register for rsp; throughput: one byte per cycle by the
// combinational eight-step fold, unless a byte waits; a byte waits only when it is
// a last byte and the result register still holds a crc that rsp has not taken
// reset: synchronous, active high; clears remainder, pipeline valids, and
// loads the default polynomial 0x436f7265
module crc32_reflected_byte_stream_core (
   input  logic                                 clock,
   input  logic                                 reset,
   crc32_rbs_req_if.sink                        req,
   crc32_rbs_rsp_if.source                      rsp,
   input  logic                                 csr_write_enable,
   input  logic [crc32_rbs_pkg::CRC_WIDTH-1:0]  csr_write_data
);

   // programmable reflected polynomial
   logic [crc32_rbs_pkg::CRC_WIDTH-1:0] poly_ff;
   logic [crc32_rbs_pkg::CRC_WIDTH-1:0] poly_in;

   // write takes effect on the next byte, remainder untouched
   assign poly_in = csr_write_enable ? csr_write_data : poly_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= crc32_rbs_pkg::POLY_RESET;
      end else begin
         poly_ff <= poly_in;
      end
   end

   // input register, fold and result register
   crc32_rbs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .polynomial (poly_ff)
   );

   // a last byte that folds leaves the remainder cleared for the next message
   assert property (@(posedge clock) disable iff (reset)
      (u_core.s1_fire && u_core.s1_last_ff) |=>
         (u_core.remainder_ff == crc32_rbs_pkg::CRC_INIT))
      else $error("remainder not cleared after last byte");

   // a result only appears after a last byte left the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(u_core.s1_valid_ff && u_core.s1_last_ff))
      else $error("result raised without a last byte");

   // every accepted byte lands in the input register
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> u_core.s1_valid_ff)
      else $error("accepted byte lost at input register");

endmodule
